@@ hw/rtl/hpfc_pkg.sv @@
`timescale 1ns / 1ps

package hpfc_pkg;

  // Longest frame counted; the byte counter saturates here
  localparam int MAX_FRAME_BYTES = 16384;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  // Header offsets reach at most 14 + 60 + 60 + 8
  localparam int OFF_W           = 8;
  localparam int CMP_W           = (POS_W > OFF_W) ? POS_W : OFF_W;

  // Protocol constants
  localparam int          ETH_LEN        = 14;
  localparam int          IP_MIN_LEN     = 20;
  localparam int          TCP_MIN_LEN    = 20;
  localparam int          TCP_DOFF_BYTE  = 12;
  localparam int          SIG_BYTES      = 4;
  localparam int          SIG_REACH      = 8;
  localparam int          MIN_HDR_WORDS  = 5;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [31:0] HTTP_WORD      = 32'h4854_5450;

  // Fixed byte positions within the frame
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IHL      = 14;
  localparam int POS_TLEN_HI  = 16;
  localparam int POS_TLEN_LO  = 17;
  localparam int POS_PROTO    = 23;

  // Configuration space
  localparam int          CFG_ADDR_W        = 2;
  localparam int          CFG_DATA_W        = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PAYLOAD = '0;
  localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd7;

  typedef enum logic [2:0] {
    VERDICT_HTTP      = 3'd0,
    VERDICT_NOT_IPV4  = 3'd1,
    VERDICT_NOT_TCP   = 3'd2,
    VERDICT_TRUNCATED = 3'd3,
    VERDICT_BAD_HLEN  = 3'd4,
    VERDICT_SHORT     = 3'd5,
    VERDICT_NO_SIG    = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       is_http;
    logic [2:0] verdict;
  } out_item_t;

endpackage

@@ hw/rtl/http_payload_frame_classifier_unit.sv @@
`timescale 1ns / 1ps

// HTTP payload frame classifier.
// Input channel (in_valid / in_stall / in_data): one Ethernet frame byte per
// item, in wire order, frame_end set on the last byte of each frame.
// Output channel (out_valid / out_stall / out_data): one verdict item per
// frame, given for the byte that carries frame_end; no result otherwise.
// Bytes pass an input register and then update the header capture state;
// the verdict of a frame enters the output register as its last byte leaves
// the input register. One byte is taken every cycle while no last byte is held back.
// A stalled output only holds back a last byte that would need the output
// register; ordinary frame bytes keep flowing into the capture state.
// APB port: min_payload_len at byte address 0, written at the access phase,
// readable at any time; pready is tied high.
// Reset (synchronous, rst_n low) empties both registers, clears the capture
// state and sets min_payload_len to 7. Frames longer than the counter limit
// count as that length and later bytes are not inspected.
module http_payload_frame_classifier_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  hpfc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output hpfc_pkg::out_item_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hpfc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [hpfc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [hpfc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int POS_W = hpfc_pkg::POS_W;
  localparam int OFF_W = hpfc_pkg::OFF_W;
  localparam int CMP_W = hpfc_pkg::CMP_W;

  // Configuration register
  logic [15:0] min_len_r;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // Capture state
  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic [3:0]       ihl_r,   ihl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [15:0]      tlen_r,  tlen_nxt;
  logic [3:0]       doff_r,  doff_nxt;
  logic [OFF_W-1:0] ps_r,    ps_nxt;
  logic [31:0]      sig_r,   sig_nxt;

  // Output register
  logic                out_vld_r;
  hpfc_pkg::out_item_t out_item_r;

  // Captured values including the current byte
  logic [POS_W-1:0] cap_pos;
  logic [15:0]      cap_etype;
  logic [3:0]       cap_ihl;
  logic [7:0]       cap_proto;
  logic [15:0]      cap_tlen;
  logic [3:0]       cap_doff;
  logic [OFF_W-1:0] cap_ps;
  logic [31:0]      cap_sig;

  logic             s1_go;
  logic             in_acc;
  logic             pos_live;
  logic [CMP_W-1:0] pos_c;
  logic [OFF_W-1:0] cur_tcp_off;
  logic [OFF_W-1:0] new_ps;

  // Verdict terms
  logic [CMP_W-1:0]     len_c;
  logic [OFF_W-1:0]     ip_len, tcp_len, tcp_off, sig_end;
  logic [OFF_W:0]       hdr_sum;
  logic [16:0]          pay_len;
  hpfc_pkg::verdict_t   verdict;

  // ---------------------------------------------------------------------------
  // Handshake: only a last byte waits for the output register
  assign s1_go    = s1_vld_r && (!s1_end_r || !out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // APB port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == hpfc_pkg::REG_MIN_PAYLOAD) begin
      prdata = hpfc_pkg::CFG_DATA_W'(min_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= hpfc_pkg::MIN_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == hpfc_pkg::REG_MIN_PAYLOAD) begin
      min_len_r <= pwdata[15:0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data.frame_byte;
      s1_end_r  <= in_data.frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Header capture for the byte in the input register
  assign pos_live    = pos_r < POS_W'(hpfc_pkg::MAX_FRAME_BYTES);
  assign pos_c       = CMP_W'(pos_r);
  assign cur_tcp_off = OFF_W'(hpfc_pkg::ETH_LEN) + {2'b00, ihl_r, 2'b00};
  assign new_ps      = cur_tcp_off + {2'b00, s1_byte_r[7:4], 2'b00};

  always_comb begin
    cap_pos   = pos_r;
    cap_etype = etype_r;
    cap_ihl   = ihl_r;
    cap_proto = proto_r;
    cap_tlen  = tlen_r;
    cap_doff  = doff_r;
    cap_ps    = ps_r;
    cap_sig   = sig_r;
    if (pos_live) begin
      cap_pos = pos_r + POS_W'(1);
      if (pos_c == CMP_W'(hpfc_pkg::POS_ETYPE_HI)) cap_etype[15:8] = s1_byte_r;
      if (pos_c == CMP_W'(hpfc_pkg::POS_ETYPE_LO)) cap_etype[7:0]  = s1_byte_r;
      if (pos_c == CMP_W'(hpfc_pkg::POS_IHL))      cap_ihl         = s1_byte_r[3:0];
      if (pos_c == CMP_W'(hpfc_pkg::POS_TLEN_HI))  cap_tlen[15:8]  = s1_byte_r;
      if (pos_c == CMP_W'(hpfc_pkg::POS_TLEN_LO))  cap_tlen[7:0]   = s1_byte_r;
      if (pos_c == CMP_W'(hpfc_pkg::POS_PROTO))    cap_proto       = s1_byte_r;
      // TCP data offset byte, located behind the IP header
      if (pos_c > CMP_W'(hpfc_pkg::POS_IHL) &&
          ihl_r >= 4'(hpfc_pkg::MIN_HDR_WORDS) &&
          pos_c == CMP_W'(cur_tcp_off + OFF_W'(hpfc_pkg::TCP_DOFF_BYTE))) begin
        cap_doff = s1_byte_r[7:4];
        if (s1_byte_r[7:4] >= 4'(hpfc_pkg::MIN_HDR_WORDS)) begin
          cap_ps = new_ps;
        end
      end
      // First payload bytes, first byte ends up highest
      if (ps_r != '0 && pos_c >= CMP_W'(ps_r) &&
          pos_c < CMP_W'(ps_r) + CMP_W'(hpfc_pkg::SIG_BYTES)) begin
        cap_sig = {sig_r[23:0], s1_byte_r};
      end
    end
  end

  // State is cleared again after every frame end
  always_comb begin
    pos_nxt   = cap_pos;
    etype_nxt = cap_etype;
    ihl_nxt   = cap_ihl;
    proto_nxt = cap_proto;
    tlen_nxt  = cap_tlen;
    doff_nxt  = cap_doff;
    ps_nxt    = cap_ps;
    sig_nxt   = cap_sig;
    if (s1_end_r) begin
      pos_nxt   = '0;
      etype_nxt = '0;
      ihl_nxt   = '0;
      proto_nxt = '0;
      tlen_nxt  = '0;
      doff_nxt  = '0;
      ps_nxt    = '0;
      sig_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      tlen_r  <= '0;
      doff_r  <= '0;
      ps_r    <= '0;
      sig_r   <= '0;
    end else if (s1_go) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      tlen_r  <= tlen_nxt;
      doff_r  <= doff_nxt;
      ps_r    <= ps_nxt;
      sig_r   <= sig_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict on the captured values; first failing check wins
  assign len_c   = CMP_W'(cap_pos);
  assign ip_len  = {2'b00, cap_ihl, 2'b00};
  assign tcp_len = {2'b00, cap_doff, 2'b00};
  assign tcp_off = OFF_W'(hpfc_pkg::ETH_LEN) + ip_len;
  assign sig_end = tcp_off + tcp_len + OFF_W'(hpfc_pkg::SIG_REACH);
  assign hdr_sum = {1'b0, ip_len} + {1'b0, tcp_len};
  assign pay_len = {1'b0, cap_tlen} - 17'(hdr_sum);

  always_comb begin
    verdict = hpfc_pkg::VERDICT_HTTP;
    priority if (len_c < CMP_W'(hpfc_pkg::ETH_LEN)) begin
      verdict = hpfc_pkg::VERDICT_TRUNCATED;
    end else if (cap_etype != hpfc_pkg::ETHERTYPE_IPV4) begin
      verdict = hpfc_pkg::VERDICT_NOT_IPV4;
    end else if (len_c < CMP_W'(hpfc_pkg::ETH_LEN + hpfc_pkg::IP_MIN_LEN)) begin
      verdict = hpfc_pkg::VERDICT_TRUNCATED;
    end else if (cap_proto != hpfc_pkg::PROTO_TCP) begin
      verdict = hpfc_pkg::VERDICT_NOT_TCP;
    end else if (cap_ihl < 4'(hpfc_pkg::MIN_HDR_WORDS)) begin
      verdict = hpfc_pkg::VERDICT_BAD_HLEN;
    end else if (len_c < CMP_W'(tcp_off) + CMP_W'(hpfc_pkg::TCP_MIN_LEN)) begin
      verdict = hpfc_pkg::VERDICT_TRUNCATED;
    end else if (cap_doff < 4'(hpfc_pkg::MIN_HDR_WORDS)) begin
      verdict = hpfc_pkg::VERDICT_BAD_HLEN;
    end else if (pay_len[16]) begin
      // Total length smaller than both headers
      verdict = hpfc_pkg::VERDICT_SHORT;
    end else if (pay_len[15:0] < min_len_r) begin
      verdict = hpfc_pkg::VERDICT_SHORT;
    end else if (len_c < CMP_W'(sig_end)) begin
      verdict = hpfc_pkg::VERDICT_TRUNCATED;
    end else if (cap_sig != hpfc_pkg::HTTP_WORD) begin
      verdict = hpfc_pkg::VERDICT_NO_SIG;
    end else begin
      verdict = hpfc_pkg::VERDICT_HTTP;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      out_item_r.is_http <= (verdict == hpfc_pkg::VERDICT_HTTP);
      out_item_r.verdict <= verdict;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s1_end_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked last byte");

  a_flag_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.is_http ==
                   (out_item_r.verdict == hpfc_pkg::VERDICT_HTTP)))
    else $error("is_http disagrees with verdict");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r ##1 out_vld_r) |-> $past(s1_go && s1_end_r))
    else $error("result appeared without a last byte");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end_r) |=> (pos_r == '0 && ps_r == '0 && sig_r == '0))
    else $error("capture state not cleared after frame end");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(hpfc_pkg::MAX_FRAME_BYTES))
    else $error("byte counter past its limit");

endmodule
